// ----- rtl/core/ets_pkg.sv -----
package ets_pkg;

  localparam int POSITION_BITS = 16;
  localparam int DEPTH_BITS    = 8;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [DEPTH_BITS-1:0]    depth_t;

  // token kinds
  localparam logic [4:0] KIND_DEC     = 5'd0;
  localparam logic [4:0] KIND_HEX     = 5'd1;
  localparam logic [4:0] KIND_BIN     = 5'd2;
  localparam logic [4:0] KIND_STRING  = 5'd3;
  localparam logic [4:0] KIND_SYMBOL  = 5'd4;
  localparam logic [4:0] KIND_BOOLEAN = 5'd5;
  localparam logic [4:0] KIND_PLUS    = 5'd6;
  localparam logic [4:0] KIND_MINUS   = 5'd7;
  localparam logic [4:0] KIND_STAR    = 5'd8;
  localparam logic [4:0] KIND_SLASH   = 5'd9;
  localparam logic [4:0] KIND_PERCENT = 5'd10;
  localparam logic [4:0] KIND_OR      = 5'd11;
  localparam logic [4:0] KIND_AND     = 5'd12;
  localparam logic [4:0] KIND_XOR     = 5'd13;
  localparam logic [4:0] KIND_TILDE   = 5'd14;
  localparam logic [4:0] KIND_LT      = 5'd15;
  localparam logic [4:0] KIND_GT      = 5'd16;
  localparam logic [4:0] KIND_BANG    = 5'd17;
  localparam logic [4:0] KIND_EQ      = 5'd18;
  localparam logic [4:0] KIND_POW     = 5'd19;
  localparam logic [4:0] KIND_LOR     = 5'd20;
  localparam logic [4:0] KIND_LAND    = 5'd21;
  localparam logic [4:0] KIND_LE      = 5'd22;
  localparam logic [4:0] KIND_GE      = 5'd23;
  localparam logic [4:0] KIND_NE      = 5'd24;
  localparam logic [4:0] KIND_LBRACK  = 5'd25;
  localparam logic [4:0] KIND_RBRACK  = 5'd26;
  localparam logic [4:0] KIND_COMMA   = 5'd27;

  // result status codes
  localparam logic [2:0] STATUS_TOKEN        = 3'd0;
  localparam logic [2:0] STATUS_END          = 3'd1;
  localparam logic [2:0] STATUS_UNEXPECTED   = 3'd2;
  localparam logic [2:0] STATUS_BAD_NUMBER   = 3'd3;
  localparam logic [2:0] STATUS_BAD_PREFIX   = 3'd4;
  localparam logic [2:0] STATUS_BAD_OPERATOR = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } ets_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic [2:0]  status;
    logic        brackets_unbalanced;
    logic        string_unterminated;
    logic        last_result;
  } ets_out_t;

endpackage

// ----- rtl/core/ets_scan.sv -----
module ets_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ets_pkg::ets_in_t item,
  output ets_pkg::ets_out_t res0,
  output ets_pkg::ets_out_t res1,
  output logic [1:0]       res_cnt
);
  import ets_pkg::*;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_DEC    = 3'd1;
  localparam logic [2:0] M_HEX    = 3'd2;
  localparam logic [2:0] M_BIN    = 3'd3;
  localparam logic [2:0] M_ZERO   = 3'd4;
  localparam logic [2:0] M_STRING = 3'd5;
  localparam logic [2:0] M_OPER   = 3'd6;
  localparam logic [2:0] M_SYMBOL = 3'd7;

  localparam logic [3:0] KW_START = 4'd0;
  localparam logic [3:0] KW_TRUE  = 4'd4;
  localparam logic [3:0] KW_FALSE = 4'd9;
  localparam logic [3:0] KW_NONE  = 4'd15;

  localparam logic [4:0] OP_NONE = 5'd0;

  logic [2:0] mode_r, mode_nxt;
  logic [4:0] pkind_r, pkind_nxt;
  pos_t       pstart_r, pstart_nxt;
  pos_t       pos_r, pos_nxt;
  depth_t     depth_r, depth_nxt;
  logic [3:0] kw_r, kw_nxt;
  logic       halted_r, halted_nxt;

  logic [7:0] c;
  logic [4:0] opk;
  logic [4:0] pair_k;
  pos_t       pos_inc;
  logic       in_class;
  logic       rescan;
  logic       open_str;
  logic       e0, e1;
  ets_out_t   ra, rb;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {["0":"9"]};
  endfunction

  function automatic logic is_sym(input logic [7:0] ch);
    return ch inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"};
  endfunction

  function automatic logic is_hex(input logic [7:0] ch);
    return ch inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch inside {" ", 8'h09, 8'h0D, 8'h0A};
  endfunction

  function automatic logic is_quote(input logic [7:0] ch);
    return ch inside {8'h27, 8'h22};
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] ch);
    logic [4:0] k;
    case (ch)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PERCENT;
      "|":     k = KIND_OR;
      "&":     k = KIND_AND;
      "^":     k = KIND_XOR;
      "~":     k = KIND_TILDE;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      "!":     k = KIND_BANG;
      "=":     k = KIND_EQ;
      default: k = OP_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] op_pair(input logic [4:0] k, input logic [7:0] ch);
    logic [4:0] p;
    case (k)
      KIND_STAR: p = (ch == "*") ? KIND_POW  : OP_NONE;
      KIND_OR:   p = (ch == "|") ? KIND_LOR  : OP_NONE;
      KIND_AND:  p = (ch == "&") ? KIND_LAND : OP_NONE;
      KIND_LT:   p = (ch == "=") ? KIND_LE   : OP_NONE;
      KIND_GT:   p = (ch == "=") ? KIND_GE   : OP_NONE;
      KIND_BANG: p = (ch == "=") ? KIND_NE   : OP_NONE;
      default:   p = OP_NONE;
    endcase
    return p;
  endfunction

  // keyword tracker: 1..4 walks "true", 5..9 walks "false"
  function automatic logic [3:0] kw_advance(input logic [3:0] p, input logic [7:0] ch);
    logic [3:0] n;
    case (p)
      4'd0:    n = (ch == "t") ? 4'd1 : ((ch == "f") ? 4'd5 : KW_NONE);
      4'd1:    n = (ch == "r") ? 4'd2 : KW_NONE;
      4'd2:    n = (ch == "u") ? 4'd3 : KW_NONE;
      4'd3:    n = (ch == "e") ? 4'd4 : KW_NONE;
      4'd5:    n = (ch == "a") ? 4'd6 : KW_NONE;
      4'd6:    n = (ch == "l") ? 4'd7 : KW_NONE;
      4'd7:    n = (ch == "s") ? 4'd8 : KW_NONE;
      4'd8:    n = (ch == "e") ? 4'd9 : KW_NONE;
      default: n = KW_NONE;
    endcase
    return n;
  endfunction

  function automatic ets_out_t mk_res(input logic [4:0] kind, input pos_t s, input pos_t e,
                                      input logic [2:0] st, input logic ub, input logic us);
    ets_out_t r;
    r.token_kind          = kind;
    r.span_start          = 16'(s);
    r.span_end            = 16'(e);
    r.status              = st;
    r.brackets_unbalanced = ub;
    r.string_unterminated = us;
    r.last_result         = 1'b0;
    return r;
  endfunction

  assign c       = item.text_byte;
  assign opk     = op_kind(c);
  assign pair_k  = op_pair(pkind_r, c);
  assign pos_inc = pos_r + POSITION_BITS'(1);

  always_comb begin
    case (mode_r)
      M_DEC:   in_class = is_digit(c);
      M_HEX:   in_class = is_hex(c);
      default: in_class = (c == "0") || (c == "1");
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pkind_nxt  = pkind_r;
    pstart_nxt = pstart_r;
    pos_nxt    = pos_inc;
    depth_nxt  = depth_r;
    kw_nxt     = kw_r;
    halted_nxt = halted_r;
    ra         = '0;
    rb         = '0;
    e0         = 1'b0;
    e1         = 1'b0;
    rescan     = 1'b0;
    open_str   = 1'b0;

    if (item.end_of_text) begin
      // close whatever is pending, then the end marker; everything returns to reset
      if (!halted_r) begin
        case (mode_r)
          M_DEC, M_HEX, M_BIN, M_OPER: begin
            e0 = 1'b1;
            ra = mk_res(pkind_r, pstart_r, pos_r, STATUS_TOKEN, 1'b0, 1'b0);
          end
          M_SYMBOL: begin
            e0 = 1'b1;
            ra = mk_res((kw_r == KW_TRUE || kw_r == KW_FALSE) ? KIND_BOOLEAN : KIND_SYMBOL,
                        pstart_r, pos_r, STATUS_TOKEN, 1'b0, 1'b0);
          end
          M_ZERO: begin
            e0 = 1'b1;
            ra = mk_res(KIND_DEC, pstart_r, pos_r, STATUS_BAD_PREFIX, 1'b0, 1'b0);
          end
          M_STRING: open_str = 1'b1;
          default: ;
        endcase
      end
      e1 = 1'b1;
      rb = mk_res(KIND_DEC, pos_r, pos_r, STATUS_END, depth_r != '0, open_str);
      mode_nxt   = M_IDLE;
      pkind_nxt  = KIND_DEC;
      pstart_nxt = '0;
      pos_nxt    = '0;
      depth_nxt  = '0;
      kw_nxt     = KW_START;
      halted_nxt = 1'b0;
    end else if (!halted_r) begin
      case (mode_r)
        M_DEC, M_HEX, M_BIN: begin
          if (in_class) begin
            e0 = 1'b0;
          end else if (is_sym(c)) begin
            e0         = 1'b1;
            ra         = mk_res(KIND_DEC, pstart_r, pos_inc, STATUS_BAD_NUMBER, 1'b0, 1'b0);
            halted_nxt = 1'b1;
            mode_nxt   = M_IDLE;
          end else begin
            e0       = 1'b1;
            ra       = mk_res(pkind_r, pstart_r, pos_r, STATUS_TOKEN, 1'b0, 1'b0);
            mode_nxt = M_IDLE;
            rescan   = 1'b1;
          end
        end
        M_ZERO: begin
          if (c == "x" || c == "X") begin
            mode_nxt  = M_HEX;
            pkind_nxt = KIND_HEX;
          end else if (c == "b" || c == "B") begin
            mode_nxt  = M_BIN;
            pkind_nxt = KIND_BIN;
          end else begin
            e0         = 1'b1;
            ra         = mk_res(KIND_DEC, pstart_r, pos_inc, STATUS_BAD_PREFIX, 1'b0, 1'b0);
            halted_nxt = 1'b1;
            mode_nxt   = M_IDLE;
          end
        end
        M_STRING: begin
          if (is_quote(c)) begin
            e0       = 1'b1;
            ra       = mk_res(KIND_STRING, pstart_r, pos_r, STATUS_TOKEN, 1'b0, 1'b0);
            mode_nxt = M_IDLE;
          end
        end
        M_OPER: begin
          if (opk != OP_NONE) begin
            e0       = 1'b1;
            mode_nxt = M_IDLE;
            if (pair_k != OP_NONE) begin
              ra = mk_res(pair_k, pstart_r, pos_inc, STATUS_TOKEN, 1'b0, 1'b0);
            end else begin
              ra         = mk_res(KIND_DEC, pstart_r, pos_inc, STATUS_BAD_OPERATOR,
                                  1'b0, 1'b0);
              halted_nxt = 1'b1;
            end
          end else begin
            // lone operator completes, this byte starts the next token
            e0       = 1'b1;
            ra       = mk_res(pkind_r, pstart_r, pos_r, STATUS_TOKEN, 1'b0, 1'b0);
            mode_nxt = M_IDLE;
            rescan   = 1'b1;
          end
        end
        M_SYMBOL: begin
          if (is_sym(c)) begin
            kw_nxt = kw_advance(kw_r, c);
          end else begin
            e0       = 1'b1;
            ra       = mk_res((kw_r == KW_TRUE || kw_r == KW_FALSE) ? KIND_BOOLEAN
                              : KIND_SYMBOL, pstart_r, pos_r, STATUS_TOKEN, 1'b0, 1'b0);
            mode_nxt = M_IDLE;
            rescan   = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          rescan   = 1'b1;
        end
      endcase

      if (rescan && !is_space(c)) begin
        pstart_nxt = pos_r;
        if (is_digit(c)) begin
          mode_nxt  = (c == "0") ? M_ZERO : M_DEC;
          pkind_nxt = KIND_DEC;
        end else if (opk != OP_NONE) begin
          if (opk inside {KIND_STAR, KIND_OR, KIND_AND, KIND_LT, KIND_GT, KIND_BANG}) begin
            mode_nxt  = M_OPER;
            pkind_nxt = opk;
          end else begin
            e1 = 1'b1;
            rb = mk_res(opk, pos_r, pos_inc, STATUS_TOKEN, 1'b0, 1'b0);
          end
        end else if (is_quote(c)) begin
          mode_nxt   = M_STRING;
          pkind_nxt  = KIND_STRING;
          pstart_nxt = pos_inc;
        end else if (is_sym(c)) begin
          mode_nxt  = M_SYMBOL;
          pkind_nxt = KIND_SYMBOL;
          kw_nxt    = kw_advance(KW_START, c);
        end else if (c inside {"(", "[", "{"}) begin
          depth_nxt = depth_r + DEPTH_BITS'(1);
          e1        = 1'b1;
          rb        = mk_res(KIND_LBRACK, pos_r, pos_inc, STATUS_TOKEN, 1'b0, 1'b0);
        end else if (c inside {")", "]", "}"}) begin
          depth_nxt = depth_r - DEPTH_BITS'(1);
          e1        = 1'b1;
          rb        = mk_res(KIND_RBRACK, pos_r, pos_inc, STATUS_TOKEN, 1'b0, 1'b0);
        end else if (c == ",") begin
          e1 = 1'b1;
          rb = mk_res(KIND_COMMA, pos_r, pos_inc, STATUS_TOKEN, 1'b0, 1'b0);
        end else begin
          e1         = 1'b1;
          rb         = mk_res(KIND_DEC, pos_r, pos_inc, STATUS_UNEXPECTED, 1'b0, 1'b0);
          halted_nxt = 1'b1;
          mode_nxt   = M_IDLE;
        end
      end
    end
  end

  // pack the results in order, the last one flagged
  always_comb begin
    res_cnt = {1'b0, e0} + {1'b0, e1};
    res0    = e0 ? ra : rb;
    res0.last_result = !(e0 && e1);
    res1    = rb;
    res1.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pkind_r  <= KIND_DEC;
      pstart_r <= '0;
      pos_r    <= '0;
      depth_r  <= '0;
      kw_r     <= KW_START;
      halted_r <= 1'b0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      pkind_r  <= pkind_nxt;
      pstart_r <= pstart_nxt;
      pos_r    <= pos_nxt;
      depth_r  <= depth_nxt;
      kw_r     <= kw_nxt;
      halted_r <= halted_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eot_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.end_of_text |=> pos_r == '0)
    else $error("position not cleared after end of text");

  a_halted_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> mode_r == M_IDLE)
    else $error("scanner halted with a token pending");

  a_eot_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.end_of_text |-> res_cnt != 2'd0 && res1.status == STATUS_END)
    else $error("end of text without end result");
`endif

endmodule

// ----- rtl/core/ets_res_fifo.sv -----
module ets_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  ets_pkg::ets_out_t push0,
  input  ets_pkg::ets_out_t push1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_stall,
  output ets_pkg::ets_out_t out_data
);
  import ets_pkg::*;

  localparam int DEPTH = 4;

  ets_out_t   entry_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = count_r != 3'd0;
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // space for the worst case of two results from one request
  assign room2     = count_r <= 3'(DEPTH - 2);

  assign wr_ptr_nxt = wr_ptr_r + push_cnt;
  assign rd_ptr_nxt = rd_ptr_r + 2'(pop);
  assign count_nxt  = count_r + 3'(push_cnt) - 3'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entry_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      entry_r[wr_ptr_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> count_r <= 3'(DEPTH - 2))
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH) && push_cnt != 2'd3)
    else $error("result queue count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule

// ----- rtl/core/expression_token_scanner.sv -----
// Streaming expression lexer, one text byte per request.
// Input channel (in_valid / in_stall / in_data): a text byte plus an
// end_of_text flag. Output channel (out_valid / out_stall / out_data):
// tokens with kind and span, error results, and one end result per text.
// A request yields zero, one or two results; the last one carries
// last_result. Whitespace yields no result of its own.
// A request is first captured in the input register, then scanned once
// the queue has room for two results; its results are written into the
// queue together, and the first is presented before the second. Throughput
// is one request per cycle while the queue has room; the output port drains
// one result per cycle when not stalled, so long runs of requests that each
// produce two results fill the queue and stall the input.
// A four-entry result queue decouples the sides: the input stalls only
// while the queue lacks room for two results. When the receiver stalls,
// out_data holds and results back up into the queue, then into the input
// register.
// Reset clears the scan state (position, bracket depth, error halt) and
// empties the queue. After an error, bytes are ignored until end_of_text.
module expression_token_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ets_pkg::ets_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ets_pkg::ets_out_t out_data
);
  import ets_pkg::*;

  logic       hold_v_r, hold_v_nxt;
  ets_in_t    hold_r;
  logic       fire;
  logic       room2;
  logic       take;
  ets_out_t   res0, res1;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;

  assign fire       = hold_v_r && room2;
  assign in_stall   = hold_v_r && !room2;
  assign take       = in_valid && !in_stall;
  assign hold_v_nxt = take || (hold_v_r && !fire);
  assign push_cnt   = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= in_data;
    end
  end

  ets_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (hold_r),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  ets_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/token_stream_checker.sv -----
module token_stream_checker
  import ets_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  ets_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  ets_out_t out_data,
  output int       mismatch_count,
  output int       results_pending
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_DEC, MODE_HEX, MODE_BIN, MODE_ZERO, MODE_STRING, MODE_OPER, MODE_SYMBOL
  } lex_mode_e;

  // keyword walk: 1..4 follow "true", 5..9 follow "false", 15 means neither
  localparam logic [3:0] KW_FRESH = 4'd0;
  localparam logic [3:0] KW_T     = 4'd1;
  localparam logic [3:0] KW_TRUE  = 4'd4;
  localparam logic [3:0] KW_F     = 4'd5;
  localparam logic [3:0] KW_FALSE = 4'd9;
  localparam logic [3:0] KW_DEAD  = 4'd15;
  // error and end results carry kind zero, and zero also means not an operator
  localparam logic [4:0] KIND_NONE = 5'd0;

  lex_mode_e  mode;
  logic [4:0] open_kind;
  pos_t       open_start;
  pos_t       cursor;
  depth_t     nesting;
  logic [3:0] kw_state;
  logic       halted;
  ets_out_t   tokens_due[$];
  string      true_word  = "true";
  string      false_word = "false";

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_quote(logic [7:0] c);
    return c == "\"" || c == "'";
  endfunction

  function automatic logic [4:0] oper_of(logic [7:0] c);
    case (c)
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      "/":     return KIND_SLASH;
      "%":     return KIND_PERCENT;
      "|":     return KIND_OR;
      "&":     return KIND_AND;
      "^":     return KIND_XOR;
      "~":     return KIND_TILDE;
      "<":     return KIND_LT;
      ">":     return KIND_GT;
      "!":     return KIND_BANG;
      "=":     return KIND_EQ;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic logic [3:0] kw_next(logic [3:0] p, logic [7:0] c);
    if (p == KW_FRESH) return (c == "t") ? KW_T : (c == "f") ? KW_F : KW_DEAD;
    if (p >= KW_T && p < KW_TRUE) return (c == true_word[p]) ? p + 4'd1 : KW_DEAD;
    if (p >= KW_F && p < KW_FALSE) begin
      return (c == false_word[p - KW_F + 4'd1]) ? p + 4'd1 : KW_DEAD;
    end
    return KW_DEAD;
  endfunction

  function automatic logic [4:0] symbol_kind();
    return (kw_state == KW_TRUE || kw_state == KW_FALSE) ? KIND_BOOLEAN : KIND_SYMBOL;
  endfunction

  function automatic void add_result(logic [4:0] kind, pos_t s, pos_t e, logic [2:0] st,
                                     logic ub, logic us);
    ets_out_t r;
    r.token_kind          = kind;
    r.span_start          = s;
    r.span_end            = e;
    r.status              = st;
    r.brackets_unbalanced = ub;
    r.string_unterminated = us;
    r.last_result         = 1'b0;
    tokens_due.push_back(r);
  endfunction

  // error span runs from s to just past the current byte, then input is dropped
  function automatic void raise_error(pos_t s, logic [2:0] st);
    add_result(KIND_NONE, s, cursor + pos_t'(1), st, 1'b0, 1'b0);
    halted = 1'b1;
    mode   = MODE_IDLE;
  endfunction

  function automatic void clear_scan();
    mode       = MODE_IDLE;
    open_kind  = '0;
    open_start = '0;
    cursor     = '0;
    nesting    = '0;
    kw_state   = KW_FRESH;
    halted     = 1'b0;
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    ets_out_t   want;
    logic [7:0] c;
    logic [4:0] k;
    logic [4:0] paired;
    logic       rescan;
    logic       in_class;
    logic       open_str;
    int         first_new;

    if (!rst_n) begin
      clear_scan();
      tokens_due.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          $error("result with none expected: kind %0d status %0d span %0d..%0d",
                 out_data.token_kind, out_data.status, out_data.span_start, out_data.span_end);
          mismatch_count++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 16'(want.token_kind), 16'(out_data.token_kind));
          check_field("span_start", want.span_start, out_data.span_start);
          check_field("span_end", want.span_end, out_data.span_end);
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("brackets_unbalanced", 16'(want.brackets_unbalanced),
                      16'(out_data.brackets_unbalanced));
          check_field("string_unterminated", 16'(want.string_unterminated),
                      16'(out_data.string_unterminated));
          check_field("last_result", 16'(want.last_result), 16'(out_data.last_result));
        end
      end

      if (in_valid && !in_stall) begin
        c         = in_data.text_byte;
        rescan    = 1'b0;
        open_str  = 1'b0;
        first_new = tokens_due.size();

        if (in_data.end_of_text) begin
          if (!halted) begin
            case (mode)
              MODE_DEC, MODE_HEX, MODE_BIN, MODE_OPER:
                add_result(open_kind, open_start, cursor, STATUS_TOKEN, 1'b0, 1'b0);
              MODE_SYMBOL:
                add_result(symbol_kind(), open_start, cursor, STATUS_TOKEN, 1'b0, 1'b0);
              MODE_ZERO:
                add_result(KIND_NONE, open_start, cursor, STATUS_BAD_PREFIX, 1'b0, 1'b0);
              MODE_STRING:
                open_str = 1'b1;
              default: ;
            endcase
          end
          add_result(KIND_NONE, cursor, cursor, STATUS_END, nesting != '0, open_str);
          clear_scan();
        end else if (halted) begin
          cursor = cursor + pos_t'(1);
        end else begin
          case (mode)
            MODE_DEC, MODE_HEX, MODE_BIN: begin
              in_class = (mode == MODE_DEC) ? is_digit(c)
                       : (mode == MODE_HEX) ? (is_digit(c) || (c >= "a" && c <= "f") ||
                                               (c >= "A" && c <= "F"))
                       : (c == "0" || c == "1");
              if (!in_class) begin
                if (is_ident(c)) begin
                  raise_error(open_start, STATUS_BAD_NUMBER);
                end else begin
                  add_result(open_kind, open_start, cursor, STATUS_TOKEN, 1'b0, 1'b0);
                  mode   = MODE_IDLE;
                  rescan = 1'b1;
                end
              end
            end
            MODE_ZERO: begin
              if (c == "x" || c == "X") begin
                mode      = MODE_HEX;
                open_kind = KIND_HEX;
              end else if (c == "b" || c == "B") begin
                mode      = MODE_BIN;
                open_kind = KIND_BIN;
              end else begin
                raise_error(open_start, STATUS_BAD_PREFIX);
              end
            end
            MODE_STRING: begin
              // either quote closes, whichever one opened
              if (is_quote(c)) begin
                add_result(KIND_STRING, open_start, cursor, STATUS_TOKEN, 1'b0, 1'b0);
                mode = MODE_IDLE;
              end
            end
            MODE_OPER: begin
              if (oper_of(c) != KIND_NONE) begin
                case (open_kind)
                  KIND_STAR: paired = (c == "*") ? KIND_POW : KIND_NONE;
                  KIND_OR:   paired = (c == "|") ? KIND_LOR : KIND_NONE;
                  KIND_AND:  paired = (c == "&") ? KIND_LAND : KIND_NONE;
                  KIND_LT:   paired = (c == "=") ? KIND_LE : KIND_NONE;
                  KIND_GT:   paired = (c == "=") ? KIND_GE : KIND_NONE;
                  KIND_BANG: paired = (c == "=") ? KIND_NE : KIND_NONE;
                  default:   paired = KIND_NONE;
                endcase
                if (paired != KIND_NONE) begin
                  add_result(paired, open_start, cursor + pos_t'(1), STATUS_TOKEN,
                             1'b0, 1'b0);
                  mode = MODE_IDLE;
                end else begin
                  raise_error(open_start, STATUS_BAD_OPERATOR);
                end
              end else begin
                add_result(open_kind, open_start, cursor, STATUS_TOKEN, 1'b0, 1'b0);
                mode   = MODE_IDLE;
                rescan = 1'b1;
              end
            end
            MODE_SYMBOL: begin
              if (is_ident(c)) begin
                kw_state = kw_next(kw_state, c);
              end else begin
                add_result(symbol_kind(), open_start, cursor, STATUS_TOKEN, 1'b0, 1'b0);
                mode   = MODE_IDLE;
                rescan = 1'b1;
              end
            end
            default: begin
              mode   = MODE_IDLE;
              rescan = 1'b1;
            end
          endcase

          // the byte that closed a token starts the next one; blanks start nothing
          if (rescan && !(c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A)) begin
            k          = oper_of(c);
            open_start = cursor;
            if (is_digit(c)) begin
              mode      = (c == "0") ? MODE_ZERO : MODE_DEC;
              open_kind = KIND_DEC;
            end else if (k != KIND_NONE) begin
              if (k == KIND_STAR || k == KIND_OR || k == KIND_AND ||
                  k == KIND_LT || k == KIND_GT || k == KIND_BANG) begin
                mode      = MODE_OPER;
                open_kind = k;
              end else begin
                add_result(k, cursor, cursor + pos_t'(1), STATUS_TOKEN, 1'b0, 1'b0);
              end
            end else if (is_quote(c)) begin
              mode       = MODE_STRING;
              open_kind  = KIND_STRING;
              open_start = cursor + pos_t'(1);
            end else if (is_ident(c)) begin
              mode      = MODE_SYMBOL;
              open_kind = KIND_SYMBOL;
              kw_state  = kw_next(KW_FRESH, c);
            end else if (c == "(" || c == "[" || c == "{") begin
              nesting = nesting + depth_t'(1);
              add_result(KIND_LBRACK, cursor, cursor + pos_t'(1), STATUS_TOKEN, 1'b0, 1'b0);
            end else if (c == ")" || c == "]" || c == "}") begin
              nesting = nesting - depth_t'(1);
              add_result(KIND_RBRACK, cursor, cursor + pos_t'(1), STATUS_TOKEN, 1'b0, 1'b0);
            end else if (c == ",") begin
              add_result(KIND_COMMA, cursor, cursor + pos_t'(1), STATUS_TOKEN, 1'b0, 1'b0);
            end else begin
              raise_error(cursor, STATUS_UNEXPECTED);
            end
          end
          cursor = cursor + pos_t'(1);
        end

        if (tokens_due.size() > first_new) begin
          want             = tokens_due.pop_back();
          want.last_result = 1'b1;
          tokens_due.push_back(want);
        end
      end
    end
    results_pending = tokens_due.size();
  end

endmodule

// ----- sim/expression_token_scanner_tb.sv -----
module expression_token_scanner_tb;
  import ets_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_REQUESTS = 800;
  localparam int DRAIN_TAIL      = 8;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ets_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ets_out_t out_data;

  int mismatch_count;
  int results_pending;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int requests_sent   = 0;
  int quiet_cycles    = 0;

  logic [7:0] text_q[$];
  logic [7:0] blank_chars[4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};
  string      oper_chars  = "+-*/%|&^~<>!=";
  string      pair_first  = "*|&<>!";
  string      pair_second = "*|&===";
  string      hex_chars   = "0123456789abcdefABCDEF";
  string      ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string      open_chars  = "([{";
  string      close_chars = ")]}";

  always #10 clk = ~clk;

  expression_token_scanner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  token_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("expression_token_scanner: mismatch");
    $finish;
  end

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic set_phase(input int p);
    case (p)
      0: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      1: begin
        sender_idle_pct = 88;
        recv_stall_pct  = 0;
      end
      2: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 88;
      end
      default: begin
        sender_idle_pct = 33;
        recv_stall_pct  = 33;
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_data.text_byte   = b;
    in_data.end_of_text = eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  // whole text, then the end marker with a random don't-care byte
  task automatic send_text_q();
    foreach (text_q[i]) send_request(text_q[i], 1'b0);
    send_request(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    push_str(s);
    send_text_q();
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  initial begin
    int         text_idx;
    int         first_random;
    int         pick;
    logic [7:0] ch;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty prefixes, brackets, comma, pair, lone bang, open string, errors
    send_text("(0x0,0b)");
    send_text("true<=!x\"");
    send_text("9a");
    send_text("&|");
    send_text("0");
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b1);
    wait_for_drain();

    // blanks still advance the offsets before and between tokens
    text_q.delete();
    repeat (12) text_q.push_back(8'h20);
    push_str("abcdefg 0x7F (");
    send_text_q();

    // enough opens to wrap the depth counter back to zero
    set_phase(2);
    text_q.delete();
    repeat (256) text_q.push_back("(");
    send_text_q();

    first_random = requests_sent;
    text_idx     = 0;
    while (requests_sent - first_random < RANDOM_REQUESTS) begin
      set_phase((text_idx / 6) % 4);
      if (text_idx == 40) wait_for_drain();
      text_q.delete();
      if ($urandom_range(9) == 0) begin
        // raw bytes, usually ending in an error
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(10)) begin
          case ($urandom_range(10))
            0: begin
              text_q.push_back(8'("1" + $urandom_range(8)));
              repeat ($urandom_range(3)) text_q.push_back(8'("0" + $urandom_range(9)));
            end
            1: begin
              text_q.push_back("0");
              text_q.push_back($urandom_range(1) ? "x" : "X");
              repeat ($urandom_range(3)) text_q.push_back(hex_chars[$urandom_range(21)]);
            end
            2: begin
              text_q.push_back("0");
              text_q.push_back($urandom_range(1) ? "b" : "B");
              repeat ($urandom_range(4)) text_q.push_back(8'("0" + $urandom_range(1)));
            end
            3: begin
              text_q.push_back($urandom_range(1) ? "\"" : "'");
              repeat ($urandom_range(5)) begin
                ch = 8'($urandom_range(255));
                if (ch == "\"" || ch == "'") ch = ".";
                text_q.push_back(ch);
              end
              text_q.push_back($urandom_range(1) ? "\"" : "'");
            end
            4: begin
              if ($urandom_range(1)) begin
                case ($urandom_range(5))
                  0:       push_str("true");
                  1:       push_str("false");
                  2:       push_str("tru");
                  3:       push_str("falsey");
                  4:       push_str("t");
                  default: push_str("f");
                endcase
              end else begin
                text_q.push_back(ident_chars[$urandom_range(52)]);
                repeat ($urandom_range(4)) text_q.push_back(ident_chars[$urandom_range(62)]);
              end
            end
            5: text_q.push_back(oper_chars[$urandom_range(12)]);
            6: begin
              pick = $urandom_range(5);
              text_q.push_back(pair_first[pick]);
              text_q.push_back(pair_second[pick]);
            end
            7: text_q.push_back(open_chars[$urandom_range(2)]);
            8: text_q.push_back(close_chars[$urandom_range(2)]);
            9: text_q.push_back(",");
            default: text_q.push_back(blank_chars[$urandom_range(3)]);
          endcase
          // mostly separated, sometimes glued so adjacent tokens interact
          if ($urandom_range(3) != 0) text_q.push_back(blank_chars[$urandom_range(3)]);
        end
      end
      send_text_q();
      text_idx++;
    end

    wait_for_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("expression_token_scanner: match");
    end else begin
      $display("expression_token_scanner: mismatch");
    end
    $finish;
  end

endmodule

// ----- expression_token_scanner.f -----
rtl/core/ets_pkg.sv
rtl/core/ets_scan.sv
rtl/core/ets_res_fifo.sv
rtl/core/expression_token_scanner.sv
sim/token_stream_checker.sv
sim/expression_token_scanner_tb.sv
